>>> src/ilir_pkg.sv
package ilir_pkg;

    localparam int FIELD_W = 11;
    localparam int VALUE_W = 64;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 88;
    localparam logic [FIELD_W-1:0] INIT_CAP_RESET = 11'd16;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_POP    = 3'd3,
        MODE_READ   = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] free_space;
        logic [FIELD_W-1:0] count_now;
        logic [VALUE_W-1:0] read_value;
        status_t            status;
    } res_t;

endpackage

>>> src/ilir_ram.sv
module ilir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ilir_obuf.sv
module ilir_obuf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ilir_pkg::res_t                 in_res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ilir_pkg::M_DATA_W-1:0]  m_tdata
);

    import ilir_pkg::*;

    logic full_reg;
    logic full_next;
    res_t res_reg;

    assign in_ready = !full_reg || m_tready;

    always_comb begin
        full_next = full_reg;
        if (in_valid && in_ready) begin
            full_next = 1'b1;
        end else if (m_tready) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = full_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

endmodule

>>> src/ilir_core.sv
module ilir_core #(
    parameter int DEPTH = 1024,
    parameter int WORD_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ilir_pkg::mode_t               in_mode,
    input  logic [ilir_pkg::FIELD_W-1:0]  in_position,
    input  logic [ilir_pkg::VALUE_W-1:0]  in_value,
    input  logic                          cfg_valid,
    input  logic [ilir_pkg::FIELD_W-1:0]  cfg_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ilir_pkg::res_t                res,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [WORD_WIDTH-1:0]         ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [WORD_WIDTH-1:0]         ram_rdata
);

    import ilir_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAB,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_DONE
    } state_t;

    function automatic logic [CW-1:0] clamp_cap(input logic [FIELD_W-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        if (vx == '0) begin
            return CW'(1);
        end else if (vx > XW'(DEPTH)) begin
            return CW'(DEPTH);
        end else begin
            return vx[CW-1:0];
        end
    endfunction

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [FIELD_W-1:0] init_reg, init_next;
    status_t status_reg, status_next;
    logic [VALUE_W-1:0] rdval_reg, rdval_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic up_reg, up_next;
    logic shift_reg, shift_next;
    logic pend_reg, pend_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] pos_inc_x;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic [CW:0]   cap_dbl;
    logic          has_room;
    logic          grow;
    logic [CW-1:0] free_c;

    assign pos_x     = XW'(in_position);
    assign count_x   = XW'(count_reg);
    assign pos_inc_x = pos_x + XW'(1);
    assign cnt_inc   = count_reg + CW'(1);
    assign cnt_dec   = count_reg - CW'(1);
    assign cap_dbl   = {cap_reg, 1'b0};
    assign grow      = !(count_reg < cap_reg);
    assign has_room  = !grow || (cap_dbl <= (CW+1)'(DEPTH));
    assign free_c    = cap_reg - count_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status     = status_reg;
    assign res.read_value = rdval_reg;
    assign res.count_now  = count_x[FIELD_W-1:0];
    assign res.free_space = FIELD_W'(free_c);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        init_next      = init_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        src_next       = src_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        pend_addr_next = pend_addr_reg;
        up_next        = up_reg;
        shift_next     = shift_reg;
        pend_next      = 1'b0;
        word_next      = word_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // retire the write half of a shift move
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end

        if (cfg_valid) begin
            init_next = cfg_data;
            if (count_reg == '0) begin
                cap_next = clamp_cap(cfg_data);
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    status_next = STAT_OK;
                    rdval_next  = '0;
                    word_next   = in_value[WORD_WIDTH-1:0];
                    pos_next    = in_position[AW-1:0];
                    shift_next  = 1'b0;
                    state_next  = S_DONE;
                    case (in_mode)
                        MODE_APPEND: begin
                            if (has_room) begin
                                if (grow) cap_next = cap_dbl[CW-1:0];
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = in_value[WORD_WIDTH-1:0];
                                count_next = cnt_inc;
                            end else begin
                                status_next = STAT_FULL;
                            end
                        end
                        MODE_INSERT: begin
                            if (pos_x > count_x) begin
                                status_next = STAT_RANGE;
                            end else if (!has_room) begin
                                status_next = STAT_FULL;
                            end else begin
                                if (grow) cap_next = cap_dbl[CW-1:0];
                                count_next = cnt_inc;
                                if (pos_x == count_x) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = in_position[AW-1:0];
                                    ram_wdata = in_value[WORD_WIDTH-1:0];
                                end else begin
                                    src_next   = cnt_dec[AW-1:0];
                                    last_next  = in_position[AW-1:0];
                                    up_next    = 1'b1;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else if (pos_x >= count_x) begin
                                status_next = STAT_RANGE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_position[AW-1:0];
                                count_next = cnt_dec;
                                shift_next = (pos_inc_x < count_x);
                                src_next   = pos_inc_x[AW-1:0];
                                last_next  = cnt_dec[AW-1:0];
                                up_next    = 1'b0;
                                state_next = S_GRAB;
                            end
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_dec[AW-1:0];
                                count_next = cnt_dec;
                                state_next = S_GRAB;
                            end
                        end
                        MODE_READ: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else if (pos_x >= count_x) begin
                                status_next = STAT_RANGE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_position[AW-1:0];
                                state_next = S_GRAB;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                            cap_next   = clamp_cap(init_reg);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GRAB: begin
                rdval_next = VALUE_W'(ram_rdata);
                state_next = shift_reg ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                // read one entry, write it one place over next cycle
                ram_re         = 1'b1;
                ram_raddr      = src_reg;
                pend_next      = 1'b1;
                pend_addr_next = up_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                if (src_reg == last_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    src_next = up_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                end
            end
            S_DRAIN: begin
                state_next = up_reg ? S_PUT : S_DONE;
            end
            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = word_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= clamp_cap(INIT_CAP_RESET);
            init_reg  <= INIT_CAP_RESET;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            init_reg  <= init_next;
            pend_reg  <= pend_next;
        end
        status_reg    <= status_next;
        rdval_reg     <= rdval_next;
        src_reg       <= src_next;
        last_reg      <= last_next;
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
        up_reg        <= up_next;
        shift_reg     <= shift_next;
        word_reg      <= word_next;
    end

endmodule

>>> src/indexed_list_insert_remove.sv
// channel   | ports                                | content
// ----------+--------------------------------------+---------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser    | one list operation per transfer
// result    | m_tvalid m_tready m_tdata            | one result per operation
// config    | cfg_valid cfg_ready cfg_data         | initial capacity register
//
// one operation at a time. read and pop fetch the word; insert shifts the words
// from pos upward, then writes the new word; remove fetches the word, then shifts
// the words above it down. the shift moves one word per cycle through the word
// RAM (one read port, one write port).
// reset clears count and control; the word RAM is not cleared, since only
// entries below the count are ever read. a result waiting in the output
// register does not block the next input transfer.
module indexed_list_insert_remove #(
    parameter int DEPTH = 1024,
    parameter int WORD_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ilir_pkg::FIELD_W-1:0]  cfg_data,   // initial_capacity
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ilir_pkg::S_DATA_W-1:0] s_tdata,    // position[10:0], element_value[74:11]
    input  logic [2:0]                    s_tuser,    // mode[2:0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ilir_pkg::M_DATA_W-1:0] m_tdata     // status[1:0], read_value[65:2],
                                                      // count_now[76:66], free_space[87:77]
);

    import ilir_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // core to output register
    logic res_valid;
    logic res_ready;
    res_t res;

    // word RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    // the user must issue register writes only while the list is idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    ilir_core #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (mode_t'(s_tuser)),
        .in_position (s_tdata[FIELD_W-1:0]),
        .in_value    (s_tdata[FIELD_W+VALUE_W-1:FIELD_W]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // word store, registered read
    ilir_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register decouples the core from the result stream
    ilir_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sim/tb_indexed_list_insert_remove.sv
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove;
    import ilir_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WORD_WIDTH = 64;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int FILL_WORDS = 128;
    // modes with no operation behind them
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic [FIELD_W-1:0] pos;
        logic [VALUE_W-1:0] value;
    } list_op_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [FIELD_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // position[10:0], element_value[74:11], zero pad
    logic [2:0] s_tuser = '0;            // mode[2:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // status, read_value, count_now, free_space

    // operations waiting to be sent, results waiting to arrive
    list_op_t op_q[$];
    res_t     result_q[$];
    list_op_t drv_op;

    // shadow of the list as the block should hold it
    logic [VALUE_W-1:0] word_mem [DEPTH];
    logic [FIELD_W-1:0] cap_reg;
    int list_count;
    int list_cap;

    // rough count seen by the stimulus generator, to aim positions
    int gen_count;
    int err_cnt = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic [7:0] stall_mask = 8'hff;
    int stall_age = 0;

    indexed_list_insert_remove #(
        .DEPTH(DEPTH),
        .WORD_WIDTH(WORD_WIDTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int clamp_cap(logic [FIELD_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEPTH) return DEPTH;
        return v;
    endfunction

    // room for one more word, doubling when full
    function automatic bit grow_for_add();
        if (list_count < list_cap) return 1'b1;
        if (list_cap * 2 > DEPTH) return 1'b0;
        list_cap = list_cap * 2;
        return 1'b1;
    endfunction

    function automatic res_t list_apply(logic [2:0] mode, logic [FIELD_W-1:0] pos,
                                        logic [VALUE_W-1:0] word);
        res_t r;
        int i;
        r.status = STAT_OK;
        r.read_value = '0;
        case (mode)
            MODE_APPEND: begin
                if (!grow_for_add()) begin
                    r.status = STAT_FULL;
                end else begin
                    word_mem[list_count] = word;
                    list_count++;
                end
            end
            MODE_INSERT: begin
                if (pos > list_count) begin
                    r.status = STAT_RANGE;
                end else if (!grow_for_add()) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = list_count; i > pos; i--) word_mem[i] = word_mem[i-1];
                    word_mem[pos] = word;
                    list_count++;
                end
            end
            MODE_REMOVE: begin
                if (list_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (pos >= list_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.read_value = word_mem[pos];
                    for (i = pos; i + 1 < list_count; i++) word_mem[i] = word_mem[i+1];
                    list_count--;
                end
            end
            MODE_POP: begin
                if (list_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    list_count--;
                    r.read_value = word_mem[list_count];
                end
            end
            MODE_READ: begin
                if (list_count == 0) r.status = STAT_EMPTY;
                else if (pos >= list_count) r.status = STAT_RANGE;
                else r.read_value = word_mem[pos];
            end
            MODE_CLEAR: begin
                list_count = 0;
                list_cap = clamp_cap(cap_reg);
            end
            default: ;
        endcase
        r.count_now = FIELD_W'(list_count);
        r.free_space = FIELD_W'(list_cap - list_count);
        return r;
    endfunction

    task automatic report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // driver: bursts of transfers with random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (op_q.size() != 0) begin
                drv_op = op_q.pop_front();
                s_tuser <= drv_op.mode;
                s_tdata <= {5'd0, drv_op.value, drv_op.pos};
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls follow a rotating mask, renewed each time the stall_age counter wraps
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= stall_mask[0];
            if (stall_age == 63) begin
                stall_age <= 0;
                if ($urandom_range(0, 2) == 0) stall_mask <= 8'hff;
                else stall_mask <= 8'($urandom) | 8'h01;
            end else begin
                stall_age <= stall_age + 1;
                stall_mask <= {stall_mask[0], stall_mask[7:1]};
            end
        end
    end

    // monitor: check results, then track config writes and accepted operations
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (result_q.size() == 0) begin
                    report($sformatf("result with nothing expected, data %h", m_tdata));
                end else begin
                    want = result_q.pop_front();
                    if (got.status != want.status)
                        report($sformatf("status %0d, expected %0d", got.status, want.status));
                    if (got.read_value != want.read_value)
                        report($sformatf("read_value %h, expected %h",
                                         got.read_value, want.read_value));
                    if (got.count_now != want.count_now)
                        report($sformatf("count_now %0d, expected %0d",
                                         got.count_now, want.count_now));
                    if (got.free_space != want.free_space)
                        report($sformatf("free_space %0d, expected %0d",
                                         got.free_space, want.free_space));
                end
            end
            if (cfg_valid && cfg_ready) begin
                cap_reg = cfg_data;
                if (list_count == 0) list_cap = clamp_cap(cfg_data);
            end
            if (s_tvalid && s_tready)
                result_q.push_back(list_apply(s_tuser, s_tdata[FIELD_W-1:0],
                                              s_tdata[FIELD_W+VALUE_W-1:FIELD_W]));
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_indexed_list_insert_remove: done, errors");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_op(logic [2:0] mode, int pos, logic [VALUE_W-1:0] value);
        list_op_t op;
        op.mode = mode;
        op.pos = FIELD_W'(pos);
        op.value = value;
        op_q.push_back(op);
        case (mode)
            MODE_APPEND: if (gen_count < DEPTH) gen_count++;
            MODE_INSERT: if (pos <= gen_count && gen_count < DEPTH) gen_count++;
            MODE_REMOVE: if (gen_count != 0 && pos < gen_count) gen_count--;
            MODE_POP:    if (gen_count != 0) gen_count--;
            MODE_CLEAR:  gen_count = 0;
            default: ;
        endcase
    endtask

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic wait_idle();
        do @(negedge aclk); while (op_q.size() != 0 || s_tvalid || result_q.size() != 0);
        gen_count = list_count;
    endtask

    task automatic write_cap(logic [FIELD_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random mix that keeps the list short so shifts stay cheap
    task automatic gen_random(int n);
        int r;
        int grow;
        int pos;
        logic [2:0] mode;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            grow = (gen_count < 6) ? 75 : (gen_count > 40) ? 25 : 50;
            if (r < 3) mode = MODE_CLEAR;
            else if (r < 5) mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else if (r < 25) mode = MODE_READ;
            else if ($urandom_range(0, 99) < grow)
                mode = ($urandom_range(0, 1) != 0) ? MODE_APPEND : MODE_INSERT;
            else
                mode = ($urandom_range(0, 1) != 0) ? MODE_REMOVE : MODE_POP;
            case ($urandom_range(0, 19))
                0: pos = $urandom_range(0, 2047);
                1: pos = gen_count + $urandom_range(0, 1);
                default: begin
                    if (mode == MODE_INSERT) pos = $urandom_range(0, gen_count);
                    else pos = (gen_count != 0) ? $urandom_range(0, gen_count - 1) : 0;
                end
            endcase
            push_op(mode, pos, rand_word());
        end
    endtask

    initial begin
        cap_reg = INIT_CAP_RESET;
        list_count = 0;
        list_cap = clamp_cap(INIT_CAP_RESET);
        gen_count = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, range edges, growth from 2, spare modes, clear
        write_cap(11'd2);
        push_op(MODE_POP, 0, '0);
        push_op(MODE_READ, 0, '0);
        push_op(MODE_REMOVE, 0, '0);
        push_op(MODE_INSERT, 1, 64'h1111_1111_1111_1111);
        push_op(MODE_INSERT, 0, '1);
        push_op(MODE_APPEND, 0, '0);
        push_op(MODE_APPEND, 0, 64'haaaa_aaaa_aaaa_aaaa);
        push_op(MODE_INSERT, 3, 64'h5555_5555_5555_5555);
        push_op(MODE_INSERT, 2047, 64'h2222_2222_2222_2222);
        push_op(MODE_INSERT, 1, 64'h0123_4567_89ab_cdef);
        push_op(MODE_READ, 0, '0);
        push_op(MODE_READ, 4, '0);
        push_op(MODE_READ, 5, '0);
        push_op(MODE_READ, 2047, '0);
        push_op(MODE_REMOVE, 1, '0);
        push_op(MODE_REMOVE, 2047, '0);
        push_op(MODE_SPARE_LO, 2047, '1);
        push_op(MODE_SPARE_HI, 0, '0);
        push_op(MODE_POP, 0, '0);
        push_op(MODE_REMOVE, 0, '0);
        push_op(MODE_CLEAR, 0, '0);
        push_op(MODE_APPEND, 0, 64'hfedc_ba98_7654_3210);
        wait_idle();

        // zero reads as one; oversize value clamps to the store size
        write_cap(11'd0);
        gen_random(100);
        wait_idle();
        write_cap(11'd2047);
        gen_random(90);
        wait_idle();
        write_cap(11'($urandom_range(3, 40)));
        gen_random(100);
        wait_idle();

        // fill from capacity 2 through several doublings, then work on a long list
        write_cap(11'd2);
        push_op(MODE_CLEAR, 0, '0);
        for (int k = 0; k < FILL_WORDS; k++) push_op(MODE_APPEND, 0, rand_word());
        push_op(MODE_APPEND, 0, '1);
        push_op(MODE_INSERT, FILL_WORDS + 1, '1);
        push_op(MODE_INSERT, FILL_WORDS + 3, '1);
        push_op(MODE_INSERT, 0, '1);
        push_op(MODE_READ, FILL_WORDS + 2, '0);
        push_op(MODE_READ, FILL_WORDS + 3, '0);
        push_op(MODE_READ, 0, '0);
        push_op(MODE_REMOVE, FILL_WORDS + 2, '0);
        push_op(MODE_POP, 0, '0);
        push_op(MODE_APPEND, 0, rand_word());
        push_op(MODE_INSERT, 60, rand_word());
        push_op(MODE_REMOVE, 0, '0);
        push_op(MODE_INSERT, 0, rand_word());
        push_op(MODE_READ, 64, '0);
        push_op(MODE_CLEAR, 0, '0);
        wait_idle();

        write_cap(11'd1024);
        gen_random(120);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb_indexed_list_insert_remove: done, clean");
        end else begin
            $display("tb_indexed_list_insert_remove: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/ilir_pkg.sv
src/ilir_ram.sv
src/ilir_obuf.sv
src/ilir_core.sv
src/indexed_list_insert_remove.sv
sim/tb_indexed_list_insert_remove.sv
